// ===== rtl/srs_pkg.sv =====
`timescale 1ns / 1ps
package srs_pkg;
    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP     = 2'd1,
        CMD_REVERSE = 2'd2,
        CMD_SORT    = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REV,
        S_SORT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] popped_value;
        logic signed [31:0] top_value;
        logic [6:0]         count;
    } t_out;

    // per-cycle operation applied to every cell
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP,
        OP_REV_EVEN,
        OP_REV_ODD,
        OP_SORT_EVEN,
        OP_SORT_ODD
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
    } t_ctl;
endpackage

// ===== rtl/srs_cell.sv =====
`timescale 1ns / 1ps
module srs_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  srs_pkg::t_ctl      i_ctl,
    input  logic               i_occ,
    input  logic               i_occ_up,
    input  logic               i_occ_dn,
    input  logic signed [31:0] i_up,
    input  logic signed [31:0] i_dn,
    output logic signed [31:0] o_data
);
    // index 0 is the top of stack; each cell talks to its two neighbors
    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic               w_even;
    logic               w_pair_dn;

    always_comb begin
        // even phase pairs (0,1),(2,3); odd phase pairs (1,2),(3,4)
        w_even    = (i_ctl.op == srs_pkg::OP_SORT_EVEN) || (i_ctl.op == srs_pkg::OP_REV_EVEN);
        w_pair_dn = ((IDX % 2) == 0) == w_even;
        n_data = r_data;
        case (i_ctl.op)
            srs_pkg::OP_PUSH: n_data = (IDX == 0) ? i_ctl.value : i_up;
            srs_pkg::OP_POP:  n_data = i_dn;
            srs_pkg::OP_REV_EVEN, srs_pkg::OP_REV_ODD: begin
                // swap every occupied pair
                if (w_pair_dn) begin
                    if (i_occ && i_occ_dn) n_data = i_dn;
                end else begin
                    if (i_occ && i_occ_up) n_data = i_up;
                end
            end
            srs_pkg::OP_SORT_EVEN, srs_pkg::OP_SORT_ODD: begin
                if (w_pair_dn) begin
                    if (i_occ && i_occ_dn && (i_dn < r_data)) n_data = i_dn;
                end else begin
                    if (i_occ && i_occ_up && (r_data < i_up)) n_data = i_up;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
endmodule

// ===== rtl/sortable_reversible_stack.sv =====
`timescale 1ns / 1ps
// Push and pop: busy only in the done state after the accepting edge, then the result strobe.
// Reverse of n entries: n neighbor-swap passes (at least one), busy throughout.
// Sort: DEPTH odd-even transposition passes through the cell row, busy throughout.
// The result strobe lasts one cycle right after busy falls and cannot be stalled.
// One item at a time; the next item may be accepted in the strobe cycle.
// Synchronous active-low reset empties the stack; entry contents are not cleared.
module sortable_reversible_stack #(
    parameter int DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  srs_pkg::t_in  i_item,
    output logic          o_strobe,
    output srs_pkg::t_out o_item
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH + 1);

    srs_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [PW-1:0]   r_pass, n_pass;
    logic            r_strobe, n_strobe;
    srs_pkg::t_out   r_out, n_out;
    srs_pkg::t_ctl   w_ctl;
    logic signed [31:0] w_data [DEPTH+1];
    logic [DEPTH-1:0]   w_occ;

    assign w_data[DEPTH] = '0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            assign w_occ[g] = (CW'(g) < r_cnt);
            srs_cell #(.IDX(g)) u_cell (
                .i_clk    (i_clk),
                .i_ctl    (w_ctl),
                .i_occ    (w_occ[g]),
                .i_occ_up (g > 0 ? w_occ[(g > 0) ? g - 1 : 0] : 1'b0),
                .i_occ_dn (g < DEPTH - 1 ? w_occ[(g < DEPTH - 1) ? g + 1 : g] : 1'b0),
                .i_up     (g > 0 ? w_data[(g > 0) ? g - 1 : 0] : 32'sd0),
                .i_dn     (w_data[g + 1]),
                .o_data   (w_data[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= srs_pkg::S_IDLE;
            r_cnt    <= '0;
            r_pass   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pass   <= n_pass;
            r_strobe <= n_strobe;
        end
        r_out <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_pass    = r_pass;
        n_strobe  = 1'b0;
        n_out     = r_out;
        w_ctl.op  = srs_pkg::OP_HOLD;
        w_ctl.value = i_item.value;
        case (r_state)
            srs_pkg::S_IDLE: begin
                if (start) begin
                    n_out.status       = srs_pkg::ST_OK;
                    n_out.popped_value = '0;
                    case (srs_pkg::t_cmd'(i_item.command))
                        srs_pkg::CMD_PUSH: begin
                            if (r_cnt >= CW'(DEPTH)) begin
                                n_out.status = srs_pkg::ST_OVERFLOW;
                            end else begin
                                w_ctl.op = srs_pkg::OP_PUSH;
                                n_cnt    = r_cnt + CW'(1);
                            end
                            n_state = srs_pkg::S_DONE;
                        end
                        srs_pkg::CMD_POP: begin
                            if (r_cnt == '0) begin
                                n_out.status = srs_pkg::ST_UNDERFLOW;
                            end else begin
                                w_ctl.op           = srs_pkg::OP_POP;
                                n_out.popped_value = w_data[0];
                                n_cnt              = r_cnt - CW'(1);
                            end
                            n_state = srs_pkg::S_DONE;
                        end
                        srs_pkg::CMD_REVERSE: begin
                            n_pass  = '0;
                            n_state = srs_pkg::S_REV;
                        end
                        default: begin
                            n_pass  = '0;
                            n_state = srs_pkg::S_SORT;
                        end
                    endcase
                end
            end
            srs_pkg::S_REV: begin
                w_ctl.op = r_pass[0] ? srs_pkg::OP_REV_ODD : srs_pkg::OP_REV_EVEN;
                n_pass   = r_pass + PW'(1);
                if ((r_pass + PW'(1)) >= r_cnt) n_state = srs_pkg::S_DONE;
            end
            srs_pkg::S_SORT: begin
                w_ctl.op = r_pass[0] ? srs_pkg::OP_SORT_ODD : srs_pkg::OP_SORT_EVEN;
                n_pass   = r_pass + PW'(1);
                if (r_pass == PW'(DEPTH - 1)) n_state = srs_pkg::S_DONE;
            end
            srs_pkg::S_DONE: begin
                n_strobe        = 1'b1;
                n_out.top_value = (r_cnt == '0) ? 32'sd0 : w_data[0];
                n_out.count     = 7'(r_cnt);
                n_state         = srs_pkg::S_IDLE;
            end
            default: n_state = srs_pkg::S_IDLE;
        endcase
    end

    assign busy     = (r_state != srs_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_item   = r_out;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("count beyond depth");
    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == srs_pkg::S_DONE)) else $error("stray strobe");
    a_cnt_stable_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srs_pkg::S_SORT) |=> $stable(r_cnt)) else $error("count moved");
`endif
endmodule

// ===== tb/tb_sortable_reversible_stack.sv =====
`timescale 1ns / 1ps
module tb_sortable_reversible_stack;
    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;

    class stack_scoreboard;
        logic signed [31:0] words[$];
        srs_pkg::t_out pending[$];
        int errors;
        int checked;

        function void sort_words();
            logic signed [31:0] key;
            int j;
            for (int i = 1; i < words.size(); i++) begin
                key = words[i];
                j = i;
                while (j > 0 && words[j-1] < key) begin
                    words[j] = words[j-1];
                    j--;
                end
                words[j] = key;
            end
        endfunction

        function void note_command(srs_pkg::t_in it);
            srs_pkg::t_out r;
            logic signed [31:0] t;
            r = '0;
            case (srs_pkg::t_cmd'(it.command))
                srs_pkg::CMD_PUSH: begin
                    if (words.size() >= DEPTH) r.status = srs_pkg::ST_OVERFLOW;
                    else words.push_back(it.value);
                end
                srs_pkg::CMD_POP: begin
                    if (words.size() == 0) r.status = srs_pkg::ST_UNDERFLOW;
                    else r.popped_value = words.pop_back();
                end
                srs_pkg::CMD_REVERSE: begin
                    for (int i = 0; i < words.size() / 2; i++) begin
                        t = words[i];
                        words[i] = words[words.size()-1-i];
                        words[words.size()-1-i] = t;
                    end
                end
                default: sort_words();
            endcase
            if (words.size() > 0) r.top_value = words[words.size()-1];
            r.count = 7'(words.size());
            pending.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(srs_pkg::t_out got);
            srs_pkg::t_out want;
            if (pending.size() == 0) begin
                report("result with nothing outstanding", 32'd0, 32'd0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.status !== want.status)
                report("status", 32'(got.status), 32'(want.status));
            if (got.popped_value !== want.popped_value)
                report("popped_value", got.popped_value, want.popped_value);
            if (got.top_value !== want.top_value)
                report("top_value", got.top_value, want.top_value);
            if (got.count !== want.count)
                report("count", 32'(got.count), 32'(want.count));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    srs_pkg::t_in  i_item;
    logic o_strobe;
    srs_pkg::t_out o_item;

    stack_scoreboard sb;
    int cycles = 0;
    int sent;
    int cmd_seen[4];

    sortable_reversible_stack #(.DEPTH(DEPTH)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) sb.check_result(o_item);
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'($urandom_range(0, 7)) - 32'sd3;
            default: return $signed($urandom());
        endcase
    endfunction

    // hold the item until accepted, then drop start
    task automatic send_item(srs_pkg::t_cmd c, logic signed [31:0] v);
        @(posedge i_clk);
        start <= 1'b1;
        i_item <= '{command: c, value: v};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command('{command: c, value: v});
        cmd_seen[c]++;
        sent++;
        start <= 1'b0;
    endtask

    task automatic idle_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int burst;
        int r;
        srs_pkg::t_cmd c;
        sb = new();
        sent = 0;
        start = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(srs_pkg::CMD_POP, 32'sd0);
        send_item(srs_pkg::CMD_REVERSE, 32'sd0);
        send_item(srs_pkg::CMD_SORT, 32'sd0);
        send_item(srs_pkg::CMD_PUSH, 32'sh7fffffff);
        send_item(srs_pkg::CMD_SORT, 32'sd5);
        send_item(srs_pkg::CMD_REVERSE, 32'sd0);
        send_item(srs_pkg::CMD_PUSH, 32'sh80000000);
        send_item(srs_pkg::CMD_PUSH, 32'sd0);
        send_item(srs_pkg::CMD_PUSH, 32'sd0);
        send_item(srs_pkg::CMD_PUSH, -32'sd1);
        send_item(srs_pkg::CMD_REVERSE, 32'sd0);
        send_item(srs_pkg::CMD_SORT, 32'sd0);
        send_item(srs_pkg::CMD_POP, 32'sd0);
        send_item(srs_pkg::CMD_POP, 32'sd0);
        for (int i = 0; i < DEPTH; i++) send_item(srs_pkg::CMD_PUSH, pick_value());
        send_item(srs_pkg::CMD_PUSH, 32'sd1);
        send_item(srs_pkg::CMD_SORT, 32'sd0);
        send_item(srs_pkg::CMD_REVERSE, 32'sd0);
        drain();
        idle_cycles(3);

        while (sent < 800) begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst; i++) begin
                r = $urandom_range(0, 99);
                if (sb.words.size() >= DEPTH - 2)
                    c = (r < 60) ? srs_pkg::CMD_POP : srs_pkg::t_cmd'(r % 4);
                else if (r < 50) c = srs_pkg::CMD_PUSH;
                else if (r < 70) c = srs_pkg::CMD_POP;
                else if (r < 85) c = srs_pkg::CMD_REVERSE;
                else c = srs_pkg::CMD_SORT;
                send_item(c, pick_value());
            end
            if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 12));
            if ($urandom_range(0, 9) == 0) drain();
            if ($urandom_range(0, 40) == 0) begin
                while (sb.words.size() > 0) send_item(srs_pkg::CMD_POP, 32'sd0);
                send_item(srs_pkg::CMD_POP, 32'sd0);
            end
        end

        drain();
        idle_cycles(DEPTH + 8);
        $display("sent %0d items (push %0d pop %0d reverse %0d sort %0d), checked %0d results",
                  sent, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], sb.checked);
        $display("covered empty and full stack edges, extreme words, ties under sort");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== sortable_reversible_stack.f =====
rtl/srs_pkg.sv
rtl/srs_cell.sv
rtl/sortable_reversible_stack.sv
tb/tb_sortable_reversible_stack.sv
